[src/ecarow_pkg.sv]
// Shared types, constants and the rule lookup of the elementary CA row stepper.
`timescale 1ns / 1ps
`default_nettype none

package ecarow_pkg;

   localparam int CELL_W      = 8;
   localparam int INDEX_W     = 11;
   localparam int RULE_W      = 8;
   localparam int MAX_RESULTS = 3;
   localparam int CNT_W       = 2;
   localparam int SLOT_W      = 2;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CELL_W-1:0] CELL_ALIVE = 8'hFF;
   localparam logic [CELL_W-1:0] CELL_DEAD  = 8'h00;
   localparam logic [RULE_W-1:0] RULE_RESET = 8'd184;

   typedef struct packed {
      logic               alive;
      logic [INDEX_W-1:0] index;
      logic               row_end;
   } result_type;

   typedef struct packed {
      result_type [MAX_RESULTS-1:0] res;
      logic [CNT_W-1:0]             count;
   } bundle_type;

   typedef struct packed {
      logic       valid;
      bundle_type bundle;
   } push_type;

   typedef struct packed {
      logic       valid;
      bundle_type bundle;
   } head_type;

   // Bit {left, center, right} of the rule gives the next state.
   function automatic logic rule_bit(input logic [RULE_W-1:0] rule,
                                     input logic left, input logic center,
                                     input logic right);
      logic [2:0] sel;
      sel = {left, center, right};
      return rule[sel];
   endfunction

endpackage

`default_nettype wire

[src/ecarow_if.sv]
// Valid/ready channel interfaces for the request and response sides.
`timescale 1ns / 1ps
`default_nettype none

interface ecarow_req_if;
   logic                         valid;
   logic                         ready;
   logic [ecarow_pkg::CELL_W-1:0] cell_in;
   logic                         row_end_in;

   modport source (output valid, output cell_in, output row_end_in, input ready);
   modport sink   (input valid, input cell_in, input row_end_in, output ready);
endinterface

interface ecarow_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [ecarow_pkg::CELL_W-1:0]  cell_out;
   logic [ecarow_pkg::INDEX_W-1:0] cell_index;
   logic                          row_end_out;

   modport source (output valid, output cell_out, output cell_index, output row_end_out,
                   input ready);
   modport sink   (input valid, input cell_out, input cell_index, input row_end_out,
                   output ready);
endinterface

`default_nettype wire

[src/ecarow_front.sv]
// Front end: accepts cells, tracks row context and builds result bundles.
`timescale 1ns / 1ps
`default_nettype none

module ecarow_front #(
   parameter int MAX_WIDTH = 2048
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   ecarow_req_if.sink                         req_chan,
   input  wire logic                          csr_write_en,
   input  wire logic [ecarow_pkg::RULE_W-1:0] csr_write_data,
   input  wire logic                          queue_full,
   output ecarow_pkg::push_type               push
);
   import ecarow_pkg::*;

   localparam int POS_W = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;
   localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_WIDTH - 1);
   localparam logic [POS_W-1:0] POS_ONE  = POS_W'(1);

   logic [RULE_W-1:0] rule_ff;
   logic              first_ff, second_ff, older_ff, newer_ff;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic              accept, c, last;
   bundle_type        bundle;

   assign req_chan.ready = !queue_full;
   assign accept = req_chan.valid && !queue_full;
   assign c      = |req_chan.cell_in;
   assign last   = req_chan.row_end_in;

   always_comb begin
      bundle = '0;
      if (pos_ff == '0) begin
         if (last) begin
            bundle.res[0] = '{rule_bit(rule_ff, c, c, c), '0, 1'b1};
            bundle.count  = CNT_W'(1);
         end
      end else if (pos_ff == POS_ONE) begin
         if (last) begin
            bundle.res[0] = '{rule_bit(rule_ff, first_ff, c, first_ff), INDEX_W'(1), 1'b0};
            bundle.res[1] = '{rule_bit(rule_ff, c, first_ff, c), '0, 1'b1};
            bundle.count  = CNT_W'(2);
         end
      end else begin
         bundle.res[0] = '{rule_bit(rule_ff, older_ff, newer_ff, c),
                           INDEX_W'(pos_ff - POS_ONE), 1'b0};
         bundle.count  = CNT_W'(1);
         if (last) begin
            bundle.res[1] = '{rule_bit(rule_ff, newer_ff, c, first_ff),
                              INDEX_W'(pos_ff), 1'b0};
            bundle.res[2] = '{rule_bit(rule_ff, c, first_ff, second_ff), '0, 1'b1};
            bundle.count  = CNT_W'(3);
         end
      end
   end

   assign push.valid  = accept && (bundle.count != '0);
   assign push.bundle = bundle;

   always_comb begin
      pos_in = pos_ff;
      if (last) begin
         pos_in = '0;
      end else if (pos_ff != POS_LAST) begin
         pos_in = pos_ff + POS_ONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rule_ff   <= RULE_RESET;
         first_ff  <= 1'b0;
         second_ff <= 1'b0;
         older_ff  <= 1'b0;
         newer_ff  <= 1'b0;
         pos_ff    <= '0;
      end else begin
         if (csr_write_en) begin
            rule_ff <= csr_write_data;
         end
         if (accept) begin
            if (pos_ff == '0) begin
               first_ff <= c;
            end
            if (pos_ff == POS_ONE) begin
               second_ff <= c;
            end
            older_ff <= newer_ff;
            newer_ff <= c;
            pos_ff   <= pos_in;
         end
      end
   end

endmodule

`default_nettype wire

[src/ecarow_queue.sv]
// Short bundle queue between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module ecarow_queue (
   input  wire logic          clock,
   input  wire logic          reset,
   input  ecarow_pkg::push_type push,
   output logic               full,
   output ecarow_pkg::head_type head,
   input  wire logic          pop
);
   import ecarow_pkg::*;

   bundle_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;
   logic              do_pop;

   assign full        = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign head.valid  = (count_ff != '0);
   assign head.bundle = entry_ff[rd_ptr_ff];
   assign do_pop      = pop && head.valid;

   always_ff @(posedge clock) begin
      if (push.valid) begin
         entry_ff[wr_ptr_ff] <= push.bundle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push.valid) begin
            wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         end
         if (push.valid && !do_pop) begin
            count_ff <= count_ff + QCNT_W'(1);
         end else if (do_pop && !push.valid) begin
            count_ff <= count_ff - QCNT_W'(1);
         end
      end
   end

endmodule

`default_nettype wire

[src/ecarow_back.sv]
// Back end: unpacks bundles into single results behind an output register.
`timescale 1ns / 1ps
`default_nettype none

module ecarow_back (
   input  wire logic          clock,
   input  wire logic          reset,
   input  ecarow_pkg::head_type head,
   output logic               pop,
   ecarow_rsp_if.source       rsp_chan
);
   import ecarow_pkg::*;

   bundle_type        hold_ff, hold_in;
   logic [SLOT_W-1:0] sel_ff, sel_in;
   logic [CNT_W-1:0]  left_ff, left_in;
   logic              out_valid_ff, out_valid_in;
   result_type        out_res_ff, out_res_in;
   logic              take;

   assign take = !out_valid_ff || rsp_chan.ready;

   always_comb begin
      hold_in      = hold_ff;
      sel_in       = sel_ff;
      left_in      = left_ff;
      out_valid_in = out_valid_ff;
      out_res_in   = out_res_ff;
      pop          = 1'b0;
      if (take) begin
         if (left_ff != '0) begin
            // advance through the held bundle
            out_valid_in = 1'b1;
            out_res_in   = hold_ff.res[sel_ff];
            sel_in       = sel_ff + SLOT_W'(1);
            left_in      = left_ff - CNT_W'(1);
         end else if (head.valid) begin
            pop          = 1'b1;
            out_valid_in = 1'b1;
            out_res_in   = head.bundle.res[0];
            hold_in      = head.bundle;
            sel_in       = SLOT_W'(1);
            left_in      = head.bundle.count - CNT_W'(1);
         end else begin
            out_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         left_ff      <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         left_ff      <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      hold_ff    <= hold_in;
      sel_ff     <= sel_in;
      out_res_ff <= out_res_in;
   end

   assign rsp_chan.valid       = out_valid_ff;
   assign rsp_chan.cell_out    = out_res_ff.alive ? CELL_ALIVE : CELL_DEAD;
   assign rsp_chan.cell_index  = out_res_ff.index;
   assign rsp_chan.row_end_out = out_res_ff.row_end;

endmodule

`default_nettype wire

[src/elementary_ca_row_step.sv]
// Top level of the streaming elementary cellular automaton row stepper.
//
// Usage:
//  - req_chan carries one cell per transaction (cell_in, nonzero = alive) and
//    row_end_in on the last cell of a row. rsp_chan carries next-generation
//    cells as 255/0 with cell_index, and row_end_out on the row's final result.
//  - csr_write_en/csr_write_data load the 8-bit rule (reset value 184). Write
//    it only while no row is in flight.
//  - Output path: a result passes through the bundle queue and the back end's
//    output register before rsp_chan offers it. Interior results lag one cell,
//    since they wait for their right neighbor.
//  - Throughput: one cell per cycle. A row of N cells yields N results; its
//    last cell releases up to three (interior, wrapped last cell, wrapped
//    cell 0), emitted one per transaction. The two-entry bundle queue
//    absorbs that burst and req_chan.ready drops only when the queue is full.
//  - Positions past MAX_WIDTH-1 saturate.
//  - Reset (synchronous) restores the rule, clears row context and the queue,
//    and drops rsp_chan.valid.
//  - When the receiver stalls, the output register holds its transaction, the
//    queue fills, then req_chan.ready goes low.
`timescale 1ns / 1ps
`default_nettype none

module elementary_ca_row_step #(
   parameter int MAX_WIDTH = 2048
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   ecarow_req_if.sink                         req_chan,
   ecarow_rsp_if.source                       rsp_chan,
   input  wire logic                          csr_write_en,
   input  wire logic [ecarow_pkg::RULE_W-1:0] csr_write_data
);
   import ecarow_pkg::*;

   push_type push;
   head_type head;
   logic     queue_full;
   logic     pop;

   // front end: classify each cell and form its result bundle
   ecarow_front #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_chan       (req_chan),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .queue_full     (queue_full),
      .push           (push)
   );

   // decouple so the front keeps taking cells while wrap results drain
   ecarow_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .full  (queue_full),
      .head  (head),
      .pop   (pop)
   );

   // back end: emit results one per transaction
   ecarow_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

[src/ecarow_checker.sv]
// Port-level checks of the row stepper, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module ecarow_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           rsp_valid,
   input wire logic                           rsp_ready,
   input wire logic [ecarow_pkg::CELL_W-1:0]  rsp_cell_out,
   input wire logic [ecarow_pkg::INDEX_W-1:0] rsp_cell_index,
   input wire logic                           rsp_row_end_out
);
   import ecarow_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_cell_out)
         && $stable(rsp_cell_index) && $stable(rsp_row_end_out))
      else $error("response changed while stalled");

   a_cell_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_cell_out == CELL_ALIVE) || (rsp_cell_out == CELL_DEAD))
      else $error("cell_out not 0 or 255");

   // the row's closing result is always the wrapped cell 0
   a_end_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_row_end_out |-> rsp_cell_index == '0)
      else $error("row end on nonzero index");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind elementary_ca_row_step ecarow_checker u_ecarow_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_cell_out    (rsp_chan.cell_out),
   .rsp_cell_index  (rsp_chan.cell_index),
   .rsp_row_end_out (rsp_chan.row_end_out)
);

`default_nettype wire
